// ===== sv/hit_peak_velocity_detector_assert.svh =====
// Assertion macros shared by the checkers of the peak velocity detector.
// Each macro places one labelled concurrent assertion, clocked on the rising
// edge and switched off while the active-low reset is asserted.
`ifndef HIT_PEAK_VELOCITY_DETECTOR_ASSERT_SVH
`define HIT_PEAK_VELOCITY_DETECTOR_ASSERT_SVH

// Same-cycle implication.
`define HPVD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hit peak velocity detector: same-cycle check failed");

// Next-cycle implication.
`define HPVD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hit peak velocity detector: next-cycle check failed");

`endif

// ===== sv/hpvd_pkg.sv =====
// ----------------------------------------------------------------------------
// hpvd_pkg
// Widths, register indexes, types and helpers shared by the peak velocity
// detector and its subtractor.
// ----------------------------------------------------------------------------
`default_nettype none

package hpvd_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int TIME_W     = 32;
	localparam int MAG_W      = 15;
	localparam int MS_W       = 16;
	localparam int VEL_W      = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int NUM_W      = 22;   // holds 126 * 32767
	localparam int DIV_STEPS  = 7;
	localparam int STEP_W     = 3;
	localparam int SUB_W      = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_HIT_THRESHOLD    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE_LEVEL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_MS      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS        = 2'd3;

	localparam logic [MAG_W-1:0] RST_HIT_THRESHOLD    = 15'd10000;
	localparam logic [MAG_W-1:0] RST_FULL_SCALE_LEVEL = 15'd30000;
	localparam logic [MS_W-1:0]  RST_COOLDOWN_MS      = 16'd200;
	localparam logic [MS_W-1:0]  RST_WINDOW_MS        = 16'd40;

	localparam logic [MAG_W-1:0] MAG_MAX = 15'h7FFF;
	// Quotient preset that becomes the top velocity after the final increment.
	localparam logic [VEL_W-1:0] QUO_TOP = 7'd126;

	typedef struct packed {
		logic [SUB_W-1:0] a;
		logic [SUB_W-1:0] b;
	} sub_req_t;

	typedef struct packed {
		logic [SUB_W-1:0] diff;
		logic             borrow;
	} sub_rsp_t;

	// Absolute value with the most negative code saturated to the largest
	// positive magnitude.
	function automatic logic [MAG_W-1:0] mag_of(input logic [SAMPLE_W-1:0] s);
		logic [SAMPLE_W-1:0] neg;
		neg = (~s) + 16'd1;
		if (!s[SAMPLE_W-1]) begin
			return s[MAG_W-1:0];
		end else if (s == 16'h8000) begin
			return MAG_MAX;
		end else begin
			return neg[MAG_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

// ===== sv/hpvd_if.sv =====
// ----------------------------------------------------------------------------
// hpvd_if
// Valid/ready channels of the peak velocity detector: sensor samples in,
// strike results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpvd_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [hpvd_pkg::SAMPLE_W-1:0] sample;
	logic        [hpvd_pkg::TIME_W-1:0]   time_ms;

	modport source (output valid, output sample, output time_ms, input ready);
	modport sink   (input valid, input sample, input time_ms, output ready);
endinterface

interface hpvd_out_if;
	logic                         valid;
	logic                         ready;
	logic [hpvd_pkg::VEL_W-1:0]   velocity;
	logic [hpvd_pkg::MAG_W-1:0]   peak_level;

	modport source (output valid, output velocity, output peak_level, input ready);
	modport sink   (input valid, input velocity, input peak_level, output ready);
endinterface

`default_nettype wire

// ===== sv/hpvd_sub.sv =====
// ----------------------------------------------------------------------------
// hpvd_sub
// Shared 32-bit subtractor with borrow, used for the timestamp differences,
// the time limit compares and every step of the velocity division.
// ----------------------------------------------------------------------------
`default_nettype none

module hpvd_sub (
	input  wire hpvd_pkg::sub_req_t req,
	output hpvd_pkg::sub_rsp_t      rsp
);

	logic [hpvd_pkg::SUB_W:0] full;

	assign full       = {1'b0, req.a} - {1'b0, req.b};
	assign rsp.diff   = full[hpvd_pkg::SUB_W-1:0];
	assign rsp.borrow = full[hpvd_pkg::SUB_W];

endmodule

`default_nettype wire

// ===== sv/hit_peak_velocity_detector.sv =====
// ----------------------------------------------------------------------------
// hit_peak_velocity_detector
// Finds strikes in a rotation-rate stream and reports one velocity and peak
// magnitude per strike, using one subtractor under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel    dir  payload                         beat when
//  samples    in   sample (s16), time_ms (u32)     valid && ready
//  hits       out  velocity (u7), peak_level (u15) valid && ready
//  cfg_*      in   cfg_index (2), cfg_data (16)    cfg_we
//
//  A sample that closes no window goes through time difference and limit test,
//  then back to ready. A closing sample goes through time difference, limit
//  test, set-up, seven restoring division steps on the shared subtractor,
//  and the result load. With full scale not above the threshold the division
//  is skipped. The result sits in an output register; the next closing
//  sample waits only if that register has not yet been taken.
//  Reset returns the detector to the idle phase with the default registers.
//
`default_nettype none

module hit_peak_velocity_detector (
	input  wire                               clk,
	input  wire                               arst_n,
	hpvd_in_if.sink                           samples,
	hpvd_out_if.source                        hits,
	input  wire                               cfg_we,
	input  wire [hpvd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [hpvd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_DIFF = 6'b000010,
		S_TEST = 6'b000100,
		S_PREP = 6'b001000,
		S_DIV  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t state_q;

	logic [hpvd_pkg::MAG_W-1:0]  thr_q;
	logic [hpvd_pkg::MAG_W-1:0]  top_q;
	logic [hpvd_pkg::MS_W-1:0]   cooldown_q;
	logic [hpvd_pkg::MS_W-1:0]   window_q;

	logic                        in_window_q;
	logic [hpvd_pkg::TIME_W-1:0] start_q;
	logic [hpvd_pkg::MAG_W-1:0]  peak_q;
	logic [hpvd_pkg::TIME_W-1:0] last_q;

	logic [hpvd_pkg::MAG_W-1:0]  mag_q;
	logic [hpvd_pkg::TIME_W-1:0] now_q;
	logic [hpvd_pkg::TIME_W-1:0] diff_q;

	logic [hpvd_pkg::NUM_W-1:0]  rem_q;
	logic [hpvd_pkg::NUM_W-1:0]  dsh_q;
	logic [hpvd_pkg::VEL_W-1:0]  quo_q;
	logic [hpvd_pkg::STEP_W-1:0] step_q;

	logic                        out_valid_q;
	logic [hpvd_pkg::VEL_W-1:0]  vel_q;
	logic [hpvd_pkg::MAG_W-1:0]  peak_out_q;

	hpvd_pkg::sub_req_t sub_req;
	hpvd_pkg::sub_rsp_t sub_rsp;

	logic                        in_beat;
	logic                        out_free;
	logic                        out_load;
	logic [hpvd_pkg::MAG_W-1:0]  clamped;
	logic [hpvd_pkg::MAG_W-1:0]  span;
	logic [hpvd_pkg::MAG_W-1:0]  den;
	logic [hpvd_pkg::NUM_W-1:0]  num;
	logic                        no_range;

	hpvd_sub u_sub (
		.req (sub_req),
		.rsp (sub_rsp)
	);

	assign samples.ready   = (state_q == S_IDLE);
	assign in_beat         = samples.valid && samples.ready;
	assign out_free        = !out_valid_q || hits.ready;
	assign out_load        = (state_q == S_OUT) && out_free;
	assign hits.valid      = out_valid_q;
	assign hits.velocity   = vel_q;
	assign hits.peak_level = peak_out_q;

	// Operand selection for the shared subtractor.
	always_comb begin
		sub_req.a = '0;
		sub_req.b = '0;
		unique case (state_q)
			S_DIFF: begin
				sub_req.a = now_q;
				sub_req.b = in_window_q ? start_q : last_q;
			end
			S_TEST: begin
				if (in_window_q) begin
					sub_req.a = diff_q;
					sub_req.b = {{(hpvd_pkg::SUB_W-hpvd_pkg::MS_W){1'b0}}, window_q};
				end else begin
					sub_req.a = {{(hpvd_pkg::SUB_W-hpvd_pkg::MS_W){1'b0}}, cooldown_q};
					sub_req.b = diff_q;
				end
			end
			S_DIV: begin
				sub_req.a = {{(hpvd_pkg::SUB_W-hpvd_pkg::NUM_W){1'b0}}, rem_q};
				sub_req.b = {{(hpvd_pkg::SUB_W-hpvd_pkg::NUM_W){1'b0}}, dsh_q};
			end
			default: begin
				sub_req.a = '0;
				sub_req.b = '0;
			end
		endcase
	end

	// Division set-up: clamp the peak, scale by 126 as (x << 7) - (x << 1).
	always_comb begin
		if (peak_q < thr_q) begin
			clamped = thr_q;
		end else if (peak_q > top_q) begin
			clamped = top_q;
		end else begin
			clamped = peak_q;
		end
		span     = clamped - thr_q;
		den      = top_q - thr_q;
		num      = {span, 7'b0} - {6'b0, span, 1'b0};
		no_range = (top_q <= thr_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= hpvd_pkg::RST_HIT_THRESHOLD;
			top_q      <= hpvd_pkg::RST_FULL_SCALE_LEVEL;
			cooldown_q <= hpvd_pkg::RST_COOLDOWN_MS;
			window_q   <= hpvd_pkg::RST_WINDOW_MS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hpvd_pkg::CFG_HIT_THRESHOLD:    thr_q      <= cfg_data[hpvd_pkg::MAG_W-1:0];
				hpvd_pkg::CFG_FULL_SCALE_LEVEL: top_q      <= cfg_data[hpvd_pkg::MAG_W-1:0];
				hpvd_pkg::CFG_COOLDOWN_MS:      cooldown_q <= cfg_data;
				hpvd_pkg::CFG_WINDOW_MS:        window_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_window_q <= 1'b0;
			start_q     <= '0;
			peak_q      <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			// A new result may be loaded in the same cycle as the old one is taken.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (hits.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					state_q <= S_TEST;
				end
				S_TEST: begin
					if (in_window_q) begin
						if (mag_q > peak_q) begin
							peak_q <= mag_q;
						end
						// No borrow means the window time has fully elapsed.
						state_q <= sub_rsp.borrow ? S_IDLE : S_PREP;
					end else begin
						// A borrow means the time since the last hit exceeds the cooldown.
						if (mag_q > thr_q && sub_rsp.borrow) begin
							in_window_q <= 1'b1;
							start_q     <= now_q;
							peak_q      <= mag_q;
						end
						state_q <= S_IDLE;
					end
				end
				S_PREP: begin
					step_q  <= '0;
					state_q <= no_range ? S_OUT : S_DIV;
				end
				S_DIV: begin
					step_q <= step_q + 3'd1;
					if (step_q == hpvd_pkg::STEP_W'(hpvd_pkg::DIV_STEPS - 1)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						last_q      <= now_q;
						in_window_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload and datapath registers.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			mag_q <= hpvd_pkg::mag_of(samples.sample);
			now_q <= samples.time_ms;
		end
		if (state_q == S_DIFF) begin
			diff_q <= sub_rsp.diff;
		end
		if (state_q == S_PREP) begin
			rem_q <= num;
			dsh_q <= {1'b0, den, 6'b0};
			quo_q <= no_range ? hpvd_pkg::QUO_TOP : '0;
		end
		if (state_q == S_DIV) begin
			if (!sub_rsp.borrow) begin
				rem_q <= sub_rsp.diff[hpvd_pkg::NUM_W-1:0];
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[hpvd_pkg::VEL_W-2:0], ~sub_rsp.borrow};
		end
		if (out_load) begin
			vel_q      <= quo_q + 7'd1;
			peak_out_q <= peak_q;
		end
	end

endmodule

`default_nettype wire

// ===== sv/hpvd_checker.sv =====
// ----------------------------------------------------------------------------
// hpvd_checker
// Port-level checks of the peak velocity detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hit_peak_velocity_detector_assert.svh"

module hpvd_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          in_valid,
	input wire                          in_ready,
	input wire                          out_valid,
	input wire                          out_ready,
	input wire [hpvd_pkg::VEL_W-1:0]    velocity,
	input wire [hpvd_pkg::MAG_W-1:0]    peak_level
);

	// A stalled result beat stays offered with its payload unchanged.
	`HPVD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(velocity) && $stable(peak_level))

	// Every sample beat leaves the sequencer busy in the following cycle.
	`HPVD_ASSERT_NEXT(a_busy_after_beat, clk, arst_n, in_valid && in_ready, !in_ready)

	// A result is only loaded while the sequencer is busy with a sample.
	`HPVD_ASSERT_IMPL(a_result_while_busy, clk, arst_n, $rose(out_valid), $past(!in_ready))

	// Velocities are never zero.
	`HPVD_ASSERT_IMPL(a_velocity_nonzero, clk, arst_n, out_valid, velocity != 7'd0)

endmodule

bind hit_peak_velocity_detector hpvd_checker u_hpvd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (samples.valid),
	.in_ready   (samples.ready),
	.out_valid  (hits.valid),
	.out_ready  (hits.ready),
	.velocity   (hits.velocity),
	.peak_level (hits.peak_level)
);

`default_nettype wire
